FILE: hdl/nfba_pkg.sv
`timescale 1ns / 1ps
package nfba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int ADDR_W     = 12;
    localparam int SIZE_W     = 13;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = SIZE_W + 1;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(NUM_BLOCKS);

    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_FREE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // scan step outcomes
    localparam logic [2:0] SCAN_NEXT  = 3'd0;
    localparam logic [2:0] SCAN_START = 3'd1;
    localparam logic [2:0] SCAN_BREAK = 3'd2;
    localparam logic [2:0] SCAN_CONT  = 3'd3;
    localparam logic [2:0] SCAN_GRANT = 3'd4;
    localparam logic [2:0] SCAN_FAIL  = 3'd5;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] start_block;
        logic              status;
    } t_out_word;

    typedef struct packed {
        logic [2:0]        act;
        logic [OFF_W-1:0]  off;
        logic [ADDR_W-1:0] rs;
        logic [SIZE_W-1:0] rem;
    } t_scan_dec;

    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] waddr;
        logic [WORD_W-1:0]  wdata;
        logic               re;
        logic [WORD_AW-1:0] raddr;
    } t_map_port;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [SIZE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_len_port;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] idx;
    } t_find;

    // lowest set bit
    function automatic t_find find_first(input logic [WORD_W-1:0] v);
        t_find r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = OFF_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/nfba_ram.sv
`timescale 1ns / 1ps
module nfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/nfba_scan.sv
`timescale 1ns / 1ps
module nfba_scan (
    input  logic [nfba_pkg::WORD_W-1:0]  i_word,
    input  logic [nfba_pkg::WORD_AW-1:0] i_widx,
    input  logic [nfba_pkg::OFF_W-1:0]   i_off,
    input  logic                         i_in_run,
    input  logic [nfba_pkg::ADDR_W-1:0]  i_rs,
    input  logic [nfba_pkg::SIZE_W-1:0]  i_rem,
    input  logic [nfba_pkg::SIZE_W-1:0]  i_size,
    input  logic [nfba_pkg::CNT_W-1:0]   i_count,
    output nfba_pkg::t_scan_dec          o_dec
);
    import nfba_pkg::*;

    logic [ADDR_W-1:0]  base;
    logic [CNT_W-1:0]   left;
    logic [CNT_W-1:0]   cnt_m1;
    logic [WORD_AW-1:0] last_w;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  lim_mask;
    logic [WORD_W-1:0]  avail;
    t_find              f;
    t_find              z;
    logic [OFF_W:0]     run_t;
    logic [ADDR_W-1:0]  rs_new;
    logic [SUM_W-1:0]   end_new;
    logic               is_last;

    always_comb begin
        base     = {i_widx, OFF_W'(0)};
        left     = i_count - CNT_W'(base);
        cnt_m1   = i_count - CNT_W'(1);
        last_w   = cnt_m1[OFF_W +: WORD_AW];
        is_last  = (i_widx == last_w);
        lo_mask  = {WORD_W{1'b1}} << i_off;
        // blocks at or beyond the count read as used
        lim_mask = (left >= CNT_W'(WORD_W)) ? {WORD_W{1'b1}}
                                            : ~({WORD_W{1'b1}} << left[OFF_W-1:0]);
        avail    = i_word & lo_mask & lim_mask;
        f        = find_first(avail);
        z        = find_first(~avail & lo_mask);
        run_t    = (z.found ? {1'b0, z.idx} : (OFF_W+1)'(WORD_W)) - {1'b0, i_off};
        rs_new   = {i_widx, f.idx};
        end_new  = SUM_W'(rs_new) + SUM_W'(i_size);

        o_dec.act = SCAN_FAIL;
        o_dec.off = i_off;
        o_dec.rs  = i_rs;
        o_dec.rem = i_rem;

        if (!i_in_run) begin
            if (!f.found) begin
                o_dec.act = is_last ? SCAN_FAIL : SCAN_NEXT;
            end else if (end_new >= SUM_W'(i_count)) begin
                o_dec.act = SCAN_FAIL;
            end else if (i_size == '0) begin
                o_dec.act = SCAN_GRANT;
                o_dec.rs  = rs_new;
            end else begin
                o_dec.act = SCAN_START;
                o_dec.rs  = rs_new;
                o_dec.rem = i_size;
                o_dec.off = f.idx;
            end
        end else begin
            if (i_rem <= SIZE_W'(run_t)) begin
                o_dec.act = SCAN_GRANT;
            end else if (z.found) begin
                o_dec.act = SCAN_BREAK;
                o_dec.off = z.idx;
            end else begin
                o_dec.act = is_last ? SCAN_FAIL : SCAN_CONT;
                o_dec.rem = i_rem - SIZE_W'(run_t);
            end
        end
    end

endmodule

FILE: hdl/nfba_ctrl.sv
`timescale 1ns / 1ps
module nfba_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [nfba_pkg::CNT_W-1:0]   i_count,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  nfba_pkg::t_in_word           i_in,
    output logic                         o_res_valid,
    output nfba_pkg::t_out_word          o_res,
    input  logic                         i_res_take,
    output nfba_pkg::t_map_port          o_map,
    input  logic [nfba_pkg::WORD_W-1:0]  i_map_rdata,
    output nfba_pkg::t_len_port          o_len,
    input  logic [nfba_pkg::SIZE_W-1:0]  i_len_rdata
);
    import nfba_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         r_state,  n_state;
    logic [ADDR_W-1:0]  r_icnt,   n_icnt;
    logic [ADDR_W-1:0]  r_ptr,    n_ptr;
    logic [SIZE_W-1:0]  r_size,   n_size;
    logic [WORD_AW-1:0] r_widx,   n_widx;
    logic [OFF_W-1:0]   r_off,    n_off;
    logic               r_in_run, n_in_run;
    logic [ADDR_W-1:0]  r_rs,     n_rs;
    logic [SIZE_W-1:0]  r_rem,    n_rem;
    logic [ADDR_W-1:0]  r_lo,     n_lo;
    logic [CNT_W-1:0]   r_hi,     n_hi;
    logic               r_set,    n_set;
    logic [WORD_AW-1:0] r_sw,     n_sw;
    t_out_word          r_res,    n_res;

    t_scan_dec            dec;
    logic [CNT_W-1:0]     cnt_m1;
    logic [SUM_W-1:0]     ptr_sum;
    logic                 restart;
    logic [ADDR_W-1:0]    p0;
    logic [SUM_W-1:0]     end_sum;
    logic [SUM_W-1:0]     len_sum;
    logic [CNT_W-1:0]     hi_m1;
    logic [WORD_AW-1:0]   last_sw;
    logic [WORD_AW:0]     hi_w;
    logic [WORD_W-1:0]    sw_mask;

    nfba_scan u_scan (
        .i_word   (i_map_rdata),
        .i_widx   (r_widx),
        .i_off    (r_off),
        .i_in_run (r_in_run),
        .i_rs     (r_rs),
        .i_rem    (r_rem),
        .i_size   (r_size),
        .i_count  (i_count),
        .o_dec    (dec)
    );

    always_comb begin
        // next-fit start point
        cnt_m1  = i_count - CNT_W'(1);
        ptr_sum = SUM_W'(r_ptr) + SUM_W'(i_in.size);
        restart = (CNT_W'(r_ptr) == cnt_m1) || (ptr_sum >= SUM_W'(cnt_m1));
        p0      = restart ? '0 : r_ptr;

        end_sum = SUM_W'(dec.rs) + SUM_W'(r_size);
        len_sum = SUM_W'(r_lo) + SUM_W'(i_len_rdata);

        // sweep word range and bit mask over [lo, hi)
        hi_m1   = r_hi - CNT_W'(1);
        last_sw = hi_m1[OFF_W +: WORD_AW];
        hi_w    = r_hi[CNT_W-1:OFF_W];
        sw_mask = {WORD_W{1'b1}};
        if (r_sw == r_lo[ADDR_W-1:OFF_W]) begin
            sw_mask = sw_mask & ({WORD_W{1'b1}} << r_lo[OFF_W-1:0]);
        end
        if ((WORD_AW+1)'(r_sw) == hi_w) begin
            sw_mask = sw_mask & ~({WORD_W{1'b1}} << r_hi[OFF_W-1:0]);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_icnt   = r_icnt;
        n_ptr    = r_ptr;
        n_size   = r_size;
        n_widx   = r_widx;
        n_off    = r_off;
        n_in_run = r_in_run;
        n_rs     = r_rs;
        n_rem    = r_rem;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_set    = r_set;
        n_sw     = r_sw;
        n_res    = r_res;

        o_map.we    = 1'b0;
        o_map.waddr = r_sw;
        o_map.wdata = r_set ? (i_map_rdata | sw_mask) : (i_map_rdata & ~sw_mask);
        o_map.re    = 1'b0;
        o_map.raddr = r_widx + WORD_AW'(1);
        o_len.we    = 1'b0;
        o_len.waddr = r_lo;
        o_len.wdata = '0;
        o_len.re    = 1'b0;
        o_len.raddr = i_in.address;

        unique case (r_state)
            ST_INIT: begin
                // clearing pass: all blocks free, all lengths zero
                o_map.we    = 1'b1;
                o_map.waddr = r_icnt[WORD_AW-1:0];
                o_map.wdata = {WORD_W{1'b1}};
                o_len.we    = 1'b1;
                o_len.waddr = r_icnt;
                o_len.wdata = '0;
                n_icnt      = r_icnt + ADDR_W'(1);
                if (r_icnt == ADDR_W'(NUM_BLOCKS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_size   = i_in.size;
                    n_lo     = i_in.address;
                    n_res    = '{start_block: '0, status: STATUS_OK};
                    n_in_run = 1'b0;
                    if (i_in.func == FUNC_ALLOC) begin
                        o_map.re    = 1'b1;
                        o_map.raddr = p0[ADDR_W-1:OFF_W];
                        n_widx      = p0[ADDR_W-1:OFF_W];
                        n_off       = p0[OFF_W-1:0];
                        n_state     = ST_SCAN;
                    end else if (CNT_W'(i_in.address) >= i_count) begin
                        n_state = ST_DONE;
                    end else begin
                        o_len.re = 1'b1;
                        n_state  = ST_LEN;
                    end
                end
            end
            ST_SCAN: begin
                unique case (dec.act) inside
                    SCAN_NEXT, SCAN_CONT: begin
                        o_map.re = 1'b1;
                        n_widx   = r_widx + WORD_AW'(1);
                        n_off    = '0;
                        n_rem    = dec.rem;
                    end
                    SCAN_START: begin
                        n_in_run = 1'b1;
                        n_rs     = dec.rs;
                        n_rem    = dec.rem;
                        n_off    = dec.off;
                    end
                    SCAN_BREAK: begin
                        n_in_run = 1'b0;
                        n_off    = dec.off;
                    end
                    SCAN_GRANT: begin
                        n_res       = '{start_block: dec.rs, status: STATUS_OK};
                        n_ptr       = end_sum[ADDR_W-1:0];
                        o_len.we    = 1'b1;
                        o_len.waddr = dec.rs;
                        o_len.wdata = r_size;
                        n_lo        = dec.rs;
                        n_hi        = end_sum[CNT_W-1:0];
                        n_set       = 1'b0;
                        if (r_size == '0) begin
                            n_state = ST_DONE;
                        end else begin
                            o_map.re    = 1'b1;
                            o_map.raddr = dec.rs[ADDR_W-1:OFF_W];
                            n_sw        = dec.rs[ADDR_W-1:OFF_W];
                            n_state     = ST_SWEEP;
                        end
                    end
                    default: begin
                        n_res   = '{start_block: '0, status: STATUS_FAIL};
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_LEN: begin
                // recorded length is cleared even when it is zero
                o_len.we    = 1'b1;
                o_len.waddr = r_lo;
                o_len.wdata = '0;
                n_hi        = (len_sum >= SUM_W'(i_count)) ? i_count : len_sum[CNT_W-1:0];
                n_set       = 1'b1;
                if (i_len_rdata == '0) begin
                    n_state = ST_DONE;
                end else begin
                    o_map.re    = 1'b1;
                    o_map.raddr = r_lo[ADDR_W-1:OFF_W];
                    n_sw        = r_lo[ADDR_W-1:OFF_W];
                    n_state     = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // write back the word read last cycle, fetch the next one
                o_map.we = 1'b1;
                if (r_sw == last_sw) begin
                    n_state = ST_DONE;
                end else begin
                    o_map.re    = 1'b1;
                    o_map.raddr = r_sw + WORD_AW'(1);
                    n_sw        = r_sw + WORD_AW'(1);
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_icnt  <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_icnt  <= n_icnt;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size   <= n_size;
        r_widx   <= n_widx;
        r_off    <= n_off;
        r_in_run <= n_in_run;
        r_rs     <= n_rs;
        r_rem    <= n_rem;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_set    <= n_set;
        r_sw     <= n_sw;
        r_res    <= n_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

endmodule

FILE: hdl/next_fit_block_allocator.sv
`timescale 1ns / 1ps
// Steps: an alloc scans bitmap words from the next-fit point, staying on a word at each run boundary,
//   then marks each granted word; a free reads the run length, then releases each word of the run.
// Throughput: one request in flight; an alloc scan walks the single read port of the 64x64 bitmap
//   memory one word a cycle, except where a run boundary holds the scan on the same word.
// Reset: synchronous active low; after release a clearing pass sets every block free and every
//   run length zero, with input ready low. Config writes are taken throughout.
module next_fit_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nfba_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  nfba_pkg::t_in_word          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output nfba_pkg::t_out_word         o_out
);
    import nfba_pkg::*;

    // block count register, clamped to 1..NUM_BLOCKS on write
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // output register: the engine may take the next word while a result waits here
    logic      r_out_valid;
    t_out_word r_out;

    logic              res_valid;
    logic              res_take;
    t_out_word         res;
    t_map_port         map_port;
    t_len_port         len_port;
    logic [WORD_W-1:0] map_rdata;
    logic [SIZE_W-1:0] len_rdata;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_count = CNT_W'(1);
        end else if (i_cfg_data > CNT_RESET) begin
            n_count = CNT_RESET;
        end else begin
            n_count = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= n_count;
        end
    end

    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    nfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_count     (r_count),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_map       (map_port),
        .i_map_rdata (map_rdata),
        .o_len       (len_port),
        .i_len_rdata (len_rdata)
    );

    // free bitmap, one bit per block, 1 = free
    nfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_port.we),
        .i_waddr (map_port.waddr),
        .i_wdata (map_port.wdata),
        .i_re    (map_port.re),
        .i_raddr (map_port.raddr),
        .o_rdata (map_rdata)
    );

    // run length recorded at each run's start block
    nfba_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (NUM_BLOCKS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_port.we),
        .i_waddr (len_port.waddr),
        .i_wdata (len_port.wdata),
        .i_re    (len_port.re),
        .i_raddr (len_port.raddr),
        .o_rdata (len_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hdl/nfba_checker.sv
`timescale 1ns / 1ps
module nfba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [nfba_pkg::CNT_W-1:0]  i_cfg_data,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input nfba_pkg::t_in_word          i_in,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input nfba_pkg::t_out_word         o_out
);
    import nfba_pkg::*;

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed or dropped while stalled");

    // one request at a time: ready drops right after a word is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a request is in flight");

    // clearing pass: no input taken right after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during reset or clearing pass");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (.*);
